// ===== src/gafp_pkg.sv =====
// Shared constants and types for the gyro angle frame parser.
package gafp_pkg;

  // Block framing
  localparam int unsigned BlockLen = 40;
  localparam int unsigned PosW     = $clog2(BlockLen);
  localparam int unsigned CntW     = PosW + 1;
  localparam int unsigned MinCount = 4;

  // Header codes
  localparam logic [7:0] HdrPos = 8'hFF;
  localparam logic [7:0] HdrNeg = 8'hFE;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RawW   = 16;
  localparam int unsigned WrapW  = 12;
  localparam int unsigned ThetaW = 16;

  // Wrap by 3600 tenths: quotient estimate is (mag * WrapRecip) >> WrapShift
  localparam logic [11:0] FullTurn  = 12'd3600;
  localparam logic [11:0] HalfTurn  = 12'd1800;
  localparam logic [14:0] WrapRecip = 15'd18641;
  localparam int unsigned WrapShift = 26;

  // Radians: round(mag * PiQ30 / (225 * 2^20))
  localparam logic [31:0] PiQ30      = 32'd3373259426;
  localparam logic [42:0] ThetaHalf  = 43'd117964800;
  localparam int unsigned ThetaShift = 20;
  localparam logic [7:0]  ThetaDiv   = 8'd225;
  localparam logic [23:0] DivRecip   = 24'd9544371;
  localparam int unsigned DivShift   = 31;

  // Checked frame entering the angle pipeline
  typedef struct packed {
    logic                   valid;
    logic signed [RawW-1:0] raw;
  } frame_t;

endpackage

// ===== src/gafp_if.sv =====
// Channel interfaces for received bytes and angle results.
interface gafp_in_if;
  logic                           valid;
  logic                           ready;
  logic [gafp_pkg::ByteW-1:0]     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gafp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gafp_pkg::RawW-1:0]    raw_tenths;
  logic signed [gafp_pkg::WrapW-1:0]   wrapped_tenths;
  logic signed [gafp_pkg::ThetaW-1:0]  theta_rad;

  modport source (output valid, output raw_tenths, output wrapped_tenths,
                  output theta_rad, input ready);
  modport sink   (input valid, input raw_tenths, input wrapped_tenths,
                  input theta_rad, output ready);
endinterface

// ===== src/gafp_angle.sv =====
// Angle pipeline: wrap to +-1800 tenths and convert to Q2.13 radians.
module gafp_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gafp_pkg::frame_t    frm_i,
  output logic                rdy_o,
  gafp_out_if.source          res_o
);

  // Stage valid bits and per-stage load enables
  logic [6:1] vld_q;
  logic [6:1] ld;

  // Stage payloads
  logic signed [15:0] raw1_q, raw2_q, raw3_q, raw4_q, raw5_q, raw6_q;
  logic               neg2_q;
  logic [15:0]        mag2_q;
  logic [3:0]         qe2_q;
  logic signed [11:0] w3_q, w4_q, w5_q, w6_q;
  logic [22:0]        y4_q, y5_q;
  logic [15:0]        qe5_q;
  logic signed [15:0] t6_q;

  // Combinational stage logic
  logic [15:0] mag1;
  logic [30:0] wprod;
  logic [15:0] turns;
  logic [16:0] diff3;
  logic [12:0] rem3;
  logic [11:0] rem3c;
  logic signed [12:0] w3_d;
  logic [10:0] wmag4;
  logic [42:0] x4;
  logic [46:0] qprod5;
  logic [23:0] sub6;
  logic [23:0] r6;
  logic [15:0] q6;

  // Advance a stage when it is empty or its successor moves
  always_comb begin
    ld[6] = !vld_q[6] || res_o.ready;
    for (int k = 5; k >= 1; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign rdy_o = ld[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[1]) vld_q[1] <= frm_i.valid;
      for (int k = 2; k <= 6; k++) begin
        if (ld[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 2: magnitude and quotient estimate for the wrap
  assign mag1  = raw1_q[15] ? 16'(16'd0 - raw1_q) : raw1_q;
  assign wprod = 31'(mag1) * 31'(gafp_pkg::WrapRecip);

  // Stage 3: remainder with one correction, then fold into +-1800
  assign turns = 16'(gafp_pkg::FullTurn) * 16'(qe2_q);
  assign diff3 = {1'b0, mag2_q} - {1'b0, turns};
  assign rem3  = diff3[12:0];
  assign rem3c = (rem3 >= 13'(gafp_pkg::FullTurn)) ?
                 12'(rem3 - 13'(gafp_pkg::FullTurn)) : rem3[11:0];

  always_comb begin
    if (rem3c > gafp_pkg::HalfTurn) begin
      w3_d = neg2_q ? $signed({1'b0, gafp_pkg::FullTurn - rem3c})
                    : $signed({1'b0, rem3c}) - $signed({1'b0, gafp_pkg::FullTurn});
    end else begin
      w3_d = neg2_q ? -$signed({1'b0, rem3c}) : $signed({1'b0, rem3c});
    end
  end

  // Stage 4: scale the magnitude by pi and drop the power-of-two part
  assign wmag4 = w3_q[11] ? 11'(12'd0 - w3_q) : w3_q[10:0];
  assign x4    = 43'(wmag4) * 43'(gafp_pkg::PiQ30) + gafp_pkg::ThetaHalf;

  // Stage 5: quotient estimate of the divide by 225
  assign qprod5 = 47'(y4_q) * 47'(gafp_pkg::DivRecip);

  // Stage 6: correct the quotient once and restore the sign
  assign sub6 = 24'(gafp_pkg::ThetaDiv) * 24'(qe5_q);
  assign r6   = {1'b0, y5_q} - sub6;
  assign q6   = (r6 >= 24'(gafp_pkg::ThetaDiv)) ? 16'(qe5_q + 16'd1) : qe5_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) raw1_q <= frm_i.raw;
    if (ld[2]) begin
      raw2_q <= raw1_q;
      neg2_q <= raw1_q[15];
      mag2_q <= mag1;
      qe2_q  <= wprod[29:26];
    end
    if (ld[3]) begin
      raw3_q <= raw2_q;
      w3_q   <= w3_d[11:0];
    end
    if (ld[4]) begin
      raw4_q <= raw3_q;
      w4_q   <= w3_q;
      y4_q   <= x4[42:20];
    end
    if (ld[5]) begin
      raw5_q <= raw4_q;
      w5_q   <= w4_q;
      y5_q   <= y4_q;
      qe5_q  <= qprod5[46:31];
    end
    if (ld[6]) begin
      raw6_q <= raw5_q;
      w6_q   <= w5_q;
      t6_q   <= w5_q[11] ? $signed(16'd0 - q6) : $signed(q6);
    end
  end

  assign res_o.valid          = vld_q[6];
  assign res_o.raw_tenths     = raw6_q;
  assign res_o.wrapped_tenths = w6_q;
  assign res_o.theta_rad      = t6_q;

  // Wrapped angle stays in the half-turn range
  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (w6_q >= -12'sd1800 && w6_q <= 12'sd1800))
    else $error("wrapped angle out of range");

  // Wrapped angle differs from the raw angle by whole turns
  a_wrap_turns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> ((int'(raw6_q) - int'(w6_q)) % 3600 == 0))
    else $error("wrap is not a whole number of turns");

  // Radians keep the sign of the wrapped angle
  a_theta_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> ((w6_q > 0 && t6_q > 0) || (w6_q < 0 && t6_q < 0) ||
                  (w6_q == 0 && t6_q == 0)))
    else $error("radian sign mismatch");

  // Radian magnitude bounded by pi
  a_theta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (t6_q >= -16'sd25736 && t6_q <= 16'sd25736))
    else $error("radian value out of range");

endmodule

// ===== src/gyro_angle_frame_parser.sv =====
// Top level: byte framing, frame check and angle result pipeline.
// Throughput: one received word per cycle, with no stall while the output is taken.
// Result path: the frame completed by a taken word is registered into the six-register
// angle pipeline (wrap, pi multiply, divide by 225), which holds while the output is not taken.
// Reset: byte history and block position clear to zero, the pipeline empties.
// A word that does not complete a valid frame only updates history and position.
module gyro_angle_frame_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  gafp_in_if.sink      rx_i,
  gafp_out_if.source   res_o
);

  logic [7:0]                    hist_q [3];
  logic [gafp_pkg::PosW-1:0]     pos_q;
  logic [gafp_pkg::PosW-1:0]     pos_eff;
  logic [gafp_pkg::PosW-1:0]     pos_d;
  logic [gafp_pkg::CntW-1:0]     cnt;
  logic                          in_rng;
  logic                          hdr_ok;
  logic [7:0]                    csum;
  logic [15:0]                   mag;
  logic                          take;
  logic                          rdy;
  gafp_pkg::frame_t              frm;

  // Position within the block, wrapping at the block length
  assign pos_eff = ({1'b0, pos_q} >= gafp_pkg::CntW'(gafp_pkg::BlockLen)) ? '0 : pos_q;
  assign cnt     = {1'b0, pos_eff} + gafp_pkg::CntW'(1);
  assign pos_d   = (cnt >= gafp_pkg::CntW'(gafp_pkg::BlockLen)) ? '0
                                                                : cnt[gafp_pkg::PosW-1:0];

  // Frame check on header, angle bytes and checksum word
  assign in_rng = (cnt >= gafp_pkg::CntW'(gafp_pkg::MinCount)) &&
                  (cnt < gafp_pkg::CntW'(gafp_pkg::BlockLen));
  assign hdr_ok = (hist_q[0] == gafp_pkg::HdrPos) || (hist_q[0] == gafp_pkg::HdrNeg);
  assign csum   = hist_q[0] + hist_q[1] + hist_q[2];
  assign mag    = {hist_q[1], hist_q[2]};

  assign take      = rx_i.valid && rdy;
  assign frm.valid = take && in_rng && hdr_ok && (rx_i.rx_byte == csum);
  assign frm.raw   = (hist_q[0] == gafp_pkg::HdrPos) ? $signed(mag)
                                                     : $signed(16'd0 - mag);

  assign rx_i.ready = rdy;

  // Shift history and advance position on each taken word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
      pos_q     <= '0;
    end else if (take) begin
      hist_q[0] <= hist_q[1];
      hist_q[1] <= hist_q[2];
      hist_q[2] <= rx_i.rx_byte;
      pos_q     <= pos_d;
    end
  end

  gafp_angle u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .frm_i  (frm),
    .rdy_o  (rdy),
    .res_o  (res_o)
  );

  // Position never leaves the block
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < gafp_pkg::CntW'(gafp_pkg::BlockLen))
    else $error("block position out of range");

  // A taken word lands at the newest history slot
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (hist_q[2] == $past(rx_i.rx_byte)))
    else $error("history did not capture word");

  // No frame is pushed before the fourth word of a block
  a_early_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm.valid |-> (pos_eff >= gafp_pkg::PosW'(gafp_pkg::MinCount - 1)))
    else $error("frame pushed too early in block");

endmodule
